// ===== hw/rtl/psg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, register map and the volume table of the sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

    localparam int NUM_CHAN = 3;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [0:0] {
        CFG_MASTER_ENABLE = 1'b0,
        CFG_CHANNEL_MASK  = 1'b1
    } t_cfg_index;

    localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
    localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
    localparam logic [3:0] REG_TONE_B_FINE   = 4'd2;
    localparam logic [3:0] REG_TONE_B_COARSE = 4'd3;
    localparam logic [3:0] REG_TONE_C_FINE   = 4'd4;
    localparam logic [3:0] REG_TONE_C_COARSE = 4'd5;
    localparam logic [3:0] REG_NOISE_PERIOD  = 4'd6;
    localparam logic [3:0] REG_MIXER_CTL     = 4'd7;
    localparam logic [3:0] REG_VOL_A         = 4'd8;
    localparam logic [3:0] REG_VOL_B         = 4'd9;
    localparam logic [3:0] REG_VOL_C         = 4'd10;
    localparam logic [3:0] REG_ENV_FINE      = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE     = 4'd13;
    localparam logic [3:0] REG_PORT_A        = 4'd14;
    localparam logic [3:0] REG_PORT_B        = 4'd15;

    typedef struct packed {
        logic       tick;
        logic       wr_period_lo;
        logic       wr_period_hi;
        logic       wr_shape;
        logic [7:0] data;
    } t_env_ctl;

    typedef struct packed {
        logic [3:0]  level_n;
        logic [15:0] period;
        logic [3:0]  shape;
    } t_env_stat;

    function automatic logic [13:0] vol_level(input logic [3:0] lvl);
        logic [13:0] v;
        unique case (lvl)
            4'd0:    v = 14'd0;
            4'd1:    v = 14'd64;
            4'd2:    v = 14'd90;
            4'd3:    v = 14'd128;
            4'd4:    v = 14'd181;
            4'd5:    v = 14'd256;
            4'd6:    v = 14'd362;
            4'd7:    v = 14'd512;
            4'd8:    v = 14'd724;
            4'd9:    v = 14'd1024;
            4'd10:   v = 14'd1448;
            4'd11:   v = 14'd2048;
            4'd12:   v = 14'd2896;
            4'd13:   v = 14'd4096;
            4'd14:   v = 14'd5793;
            default: v = 14'd8191;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/psg_env.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_env
// Envelope generator: period counter, step counter and shape sequencing.
// ----------------------------------------------------------------------------
module psg_env
    import psg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_env_ctl  i_ctl,
    output t_env_stat o_stat
);

    logic [15:0] r_period, n_period;
    logic [15:0] r_count, n_count;
    logic [3:0]  r_step, n_step;
    logic        r_rising, n_rising;
    logic        r_stopped, n_stopped;
    logic [3:0]  r_shape, n_shape;
    logic [15:0] w_period_min;
    logic [15:0] w_count_dec;

    assign w_period_min = (r_period == '0) ? 16'd1 : r_period;
    assign w_count_dec  = (r_count == '0) ? '0 : r_count - 16'd1;

    always_comb begin
        n_period  = r_period;
        n_count   = r_count;
        n_step    = r_step;
        n_rising  = r_rising;
        n_stopped = r_stopped;
        n_shape   = r_shape;
        if (i_ctl.wr_period_lo) begin
            n_period = {r_period[15:8], i_ctl.data};
        end
        if (i_ctl.wr_period_hi) begin
            n_period = {i_ctl.data, r_period[7:0]};
        end
        if (i_ctl.wr_shape) begin
            // restart from the bottom on attack, else from the top
            n_shape   = i_ctl.data[3:0];
            n_stopped = 1'b0;
            n_rising  = i_ctl.data[2];
            n_step    = i_ctl.data[2] ? 4'd0 : 4'd15;
            n_count   = w_period_min;
        end
        if (i_ctl.tick && !r_stopped) begin
            if (w_count_dec != '0) begin
                n_count = w_count_dec;
            end else begin
                n_count = w_period_min;
                priority if (r_rising && r_step != 4'd15) begin
                    n_step = r_step + 4'd1;
                end else if (!r_rising && r_step != 4'd0) begin
                    n_step = r_step - 4'd1;
                end else if (!r_shape[3]) begin
                    n_step    = 4'd0;
                    n_stopped = 1'b1;
                end else if (r_shape[0]) begin
                    if (r_shape[1]) begin
                        n_step = r_step ^ 4'd15;
                    end
                    n_stopped = 1'b1;
                end else if (r_shape[1]) begin
                    n_rising = ~r_rising;
                end else begin
                    n_step = r_rising ? 4'd0 : 4'd15;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= '0;
            r_count   <= 16'd1;
            r_step    <= 4'd15;
            r_rising  <= 1'b0;
            r_stopped <= 1'b0;
            r_shape   <= '0;
        end else begin
            r_period  <= n_period;
            r_count   <= n_count;
            r_step    <= n_step;
            r_rising  <= n_rising;
            r_stopped <= n_stopped;
            r_shape   <= n_shape;
        end
    end

    assign o_stat.level_n = n_step;
    assign o_stat.period  = r_period;
    assign o_stat.shape   = r_shape;

endmodule

// ===== hw/rtl/psg_tone_noise_envelope.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_tone_noise_envelope
// Three-channel tone, noise and envelope sound generator with register bus.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one item per master clock tick, register write or register
//   read; the kind travels on s_tuser, the address, data and pin levels on
//   s_tdata. Master stream: one result item per input item carrying the read
//   data, the mixed sample and both port latches with their strobes.
//   Configuration: i_cfg_we writes master enable (index 0) or the channel
//   mask (index 1); write only while no item is in flight.
//   Path: an item is taken into the input register, and its result is
//   registered into the output register once that register is free.
//   Throughput: one item per cycle while m_tready is high; the input and
//   output registers together let a new item enter while a result waits.
//   Stall: while m_tready is low the result holds; one more item is taken
//   into the input register, then s_tready drops.
//   Reset: synchronous, active low; all generator state returns to its
//   power-up values and both stages empty.
// ----------------------------------------------------------------------------
module psg_tone_noise_envelope
    import psg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [3:0] reg_addr, [11:4] data, [19:12] port_a_pins, [27:20] port_b_pins
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] action
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] read_value, [23:8] mixed_sample, [31:24] port_a_value,
    // [32] port_a_strobe, [40:33] port_b_value, [41] port_b_strobe
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [2:0]            i_cfg_data
);

    // input stage
    logic        r_in_valid;
    logic [1:0]  r_in_action;
    logic [3:0]  r_in_addr;
    logic [7:0]  r_in_data;
    logic [7:0]  r_in_pa;
    logic [7:0]  r_in_pb;
    logic        w_adv;

    // output stage
    logic               r_out_valid;
    logic [7:0]         r_out_rd;
    logic signed [15:0] r_out_sample;
    logic [1:0]         r_out_strobe;
    logic [7:0]         r_out_latch_a;
    logic [7:0]         r_out_latch_b;

    // configuration
    logic       r_master_enable;
    logic [2:0] r_channel_mask;

    // generator state
    logic [3:0]  r_prescale, n_prescale;
    logic [3:0]  r_env_prescale, n_env_prescale;
    logic [11:0] r_tone_period [NUM_CHAN];
    logic [11:0] n_tone_period [NUM_CHAN];
    logic [11:0] r_tone_count [NUM_CHAN];
    logic [11:0] n_tone_count [NUM_CHAN];
    logic [2:0]  r_tone_level, n_tone_level;
    logic [2:0]  r_tone_dis, n_tone_dis;
    logic [2:0]  r_noise_dis, n_noise_dis;
    logic [3:0]  r_fixed_vol [NUM_CHAN];
    logic [3:0]  n_fixed_vol [NUM_CHAN];
    logic [2:0]  r_use_env, n_use_env;
    logic [4:0]  r_noise_period, n_noise_period;
    logic [4:0]  r_noise_count, n_noise_count;
    logic        r_noise_level, n_noise_level;
    logic [16:0] r_noise_shift, n_noise_shift;
    logic        r_noise_half, n_noise_half;
    logic [1:0]  r_port_oe, n_port_oe;
    logic [7:0]  r_port_latch [2];
    logic [7:0]  n_port_latch [2];

    logic [1:0]         n_strobe;
    logic [7:0]         n_rd;
    logic signed [15:0] n_sample;
    logic               w_slow;
    logic [11:0]        w_tone_dec;
    logic [4:0]         w_noise_dec;
    logic [3:0]         w_lvl;
    logic signed [15:0] w_vol;
    t_env_ctl           w_env_ctl;
    t_env_stat          w_env_stat;

    assign w_adv    = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_action <= s_tuser;
            r_in_addr   <= s_tdata[3:0];
            r_in_data   <= s_tdata[11:4];
            r_in_pa     <= s_tdata[19:12];
            r_in_pb     <= s_tdata[27:20];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_enable <= 1'b1;
            r_channel_mask  <= 3'd7;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MASTER_ENABLE: r_master_enable <= i_cfg_data[0];
                CFG_CHANNEL_MASK:  r_channel_mask  <= i_cfg_data;
                default:           r_master_enable <= r_master_enable;
            endcase
        end
    end

    assign w_slow = w_adv && (r_in_action == ACT_TICK) && (r_prescale == '0);

    always_comb begin
        w_env_ctl.tick         = w_slow && (r_env_prescale == '0);
        w_env_ctl.wr_period_lo = 1'b0;
        w_env_ctl.wr_period_hi = 1'b0;
        w_env_ctl.wr_shape     = 1'b0;
        w_env_ctl.data         = r_in_data;
        if (w_adv && r_in_action == ACT_WRITE) begin
            w_env_ctl.wr_period_lo = (r_in_addr == REG_ENV_FINE);
            w_env_ctl.wr_period_hi = (r_in_addr == REG_ENV_COARSE);
            w_env_ctl.wr_shape     = (r_in_addr == REG_ENV_SHAPE);
        end
    end

    psg_env u_env (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_env_ctl),
        .o_stat  (w_env_stat)
    );

    always_comb begin
        n_prescale     = r_prescale;
        n_env_prescale = r_env_prescale;
        n_tone_period  = r_tone_period;
        n_tone_count   = r_tone_count;
        n_tone_level   = r_tone_level;
        n_tone_dis     = r_tone_dis;
        n_noise_dis    = r_noise_dis;
        n_fixed_vol    = r_fixed_vol;
        n_use_env      = r_use_env;
        n_noise_period = r_noise_period;
        n_noise_count  = r_noise_count;
        n_noise_level  = r_noise_level;
        n_noise_shift  = r_noise_shift;
        n_noise_half   = r_noise_half;
        n_port_oe      = r_port_oe;
        n_port_latch   = r_port_latch;
        n_strobe       = '0;
        n_rd           = '0;
        w_tone_dec     = '0;
        w_noise_dec    = '0;

        if (w_adv && r_in_action == ACT_TICK) begin
            n_prescale = r_prescale + 4'd1;
        end

        if (w_slow) begin
            n_env_prescale = r_env_prescale + 4'd1;
            for (int i = 0; i < NUM_CHAN; i++) begin
                w_tone_dec = (r_tone_count[i] == '0) ? '0 : r_tone_count[i] - 12'd1;
                n_tone_count[i] = w_tone_dec;
                if (w_tone_dec == '0) begin
                    n_tone_count[i] = (r_tone_period[i] == '0) ? 12'd1 : r_tone_period[i];
                    n_tone_level[i] = ~r_tone_level[i];
                end
            end
            w_noise_dec   = (r_noise_count == '0) ? '0 : r_noise_count - 5'd1;
            n_noise_count = w_noise_dec;
            if (w_noise_dec == '0) begin
                n_noise_count = (r_noise_period == '0) ? 5'd1 : r_noise_period;
                n_noise_half  = ~r_noise_half;
                if (!r_noise_half) begin
                    n_noise_level = ~r_noise_shift[0];
                    n_noise_shift = {r_noise_shift[0] ^ r_noise_shift[3], r_noise_shift[16:1]};
                end
            end
        end

        if (w_adv && r_in_action == ACT_WRITE) begin
            unique case (r_in_addr)
                REG_TONE_A_FINE, REG_TONE_B_FINE, REG_TONE_C_FINE: begin
                    n_tone_period[r_in_addr[2:1]] =
                        {r_tone_period[r_in_addr[2:1]][11:8], r_in_data};
                end
                REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE: begin
                    n_tone_period[r_in_addr[2:1]] =
                        {r_in_data[3:0], r_tone_period[r_in_addr[2:1]][7:0]};
                end
                REG_NOISE_PERIOD: n_noise_period = r_in_data[4:0];
                REG_MIXER_CTL: begin
                    n_tone_dis  = r_in_data[2:0];
                    n_noise_dis = r_in_data[5:3];
                    n_port_oe   = r_in_data[7:6];
                    n_strobe    = r_in_data[7:6] & ~r_port_oe;
                end
                REG_VOL_A, REG_VOL_B, REG_VOL_C: begin
                    n_fixed_vol[r_in_addr[1:0]] = r_in_data[3:0];
                    n_use_env[r_in_addr[1:0]]   = r_in_data[4];
                end
                REG_PORT_A: begin
                    n_port_latch[0] = r_in_data;
                    n_strobe[0]     = r_port_oe[0];
                end
                REG_PORT_B: begin
                    n_port_latch[1] = r_in_data;
                    n_strobe[1]     = r_port_oe[1];
                end
                default: n_strobe = '0;
            endcase
        end

        if (r_in_action == ACT_READ) begin
            unique case (r_in_addr)
                REG_TONE_A_FINE, REG_TONE_B_FINE, REG_TONE_C_FINE:
                    n_rd = r_tone_period[r_in_addr[2:1]][7:0];
                REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE:
                    n_rd = {4'd0, r_tone_period[r_in_addr[2:1]][11:8]};
                REG_NOISE_PERIOD: n_rd = {3'd0, r_noise_period};
                REG_MIXER_CTL:    n_rd = {r_port_oe, r_noise_dis, r_tone_dis};
                REG_VOL_A, REG_VOL_B, REG_VOL_C:
                    n_rd = {3'd0, r_use_env[r_in_addr[1:0]], r_fixed_vol[r_in_addr[1:0]]};
                REG_ENV_FINE:     n_rd = w_env_stat.period[7:0];
                REG_ENV_COARSE:   n_rd = w_env_stat.period[15:8];
                REG_ENV_SHAPE:    n_rd = {4'd0, w_env_stat.shape};
                REG_PORT_A:       n_rd = r_port_oe[0] ? r_port_latch[0] : r_in_pa;
                default:          n_rd = r_port_oe[1] ? r_port_latch[1] : r_in_pb;
            endcase
        end
    end

    // mix from the state after this item
    always_comb begin
        n_sample = '0;
        w_lvl    = '0;
        w_vol    = '0;
        if (r_master_enable) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
                w_lvl = n_use_env[i] ? w_env_stat.level_n : n_fixed_vol[i];
                w_vol = signed'({2'b00, vol_level(w_lvl)});
                if (r_channel_mask[i]) begin
                    if ((n_tone_level[i] || n_tone_dis[i]) &&
                        (n_noise_level || n_noise_dis[i])) begin
                        n_sample = n_sample + w_vol;
                    end else begin
                        n_sample = n_sample - w_vol;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale     <= '0;
            r_env_prescale <= '0;
            r_tone_level   <= '1;
            r_tone_dis     <= '1;
            r_noise_dis    <= '1;
            r_use_env      <= '0;
            r_noise_period <= '0;
            r_noise_count  <= '0;
            r_noise_level  <= 1'b1;
            r_noise_shift  <= 17'd1;
            r_noise_half   <= 1'b0;
            r_port_oe      <= '0;
            for (int i = 0; i < NUM_CHAN; i++) begin
                r_tone_period[i] <= '0;
                r_tone_count[i]  <= '0;
                r_fixed_vol[i]   <= '0;
            end
            r_port_latch[0] <= '0;
            r_port_latch[1] <= '0;
        end else begin
            r_prescale     <= n_prescale;
            r_env_prescale <= n_env_prescale;
            r_tone_period  <= n_tone_period;
            r_tone_count   <= n_tone_count;
            r_tone_level   <= n_tone_level;
            r_tone_dis     <= n_tone_dis;
            r_noise_dis    <= n_noise_dis;
            r_fixed_vol    <= n_fixed_vol;
            r_use_env      <= n_use_env;
            r_noise_period <= n_noise_period;
            r_noise_count  <= n_noise_count;
            r_noise_level  <= n_noise_level;
            r_noise_shift  <= n_noise_shift;
            r_noise_half   <= n_noise_half;
            r_port_oe      <= n_port_oe;
            r_port_latch   <= n_port_latch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_rd      <= n_rd;
            r_out_sample  <= n_sample;
            r_out_strobe  <= n_strobe;
            r_out_latch_a <= n_port_latch[0];
            r_out_latch_b <= n_port_latch[1];
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'd0, r_out_strobe[1], r_out_latch_b, r_out_strobe[0],
                       r_out_latch_a, r_out_sample, r_out_rd};

    a_mute_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_master_enable) |=> (r_out_sample == '0))
        else $error("muted sample not zero");

    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_action != ACT_READ) |=> (r_out_rd == '0))
        else $error("read data on a non-read item");

    a_strobe_oe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_strobe[0]) |=> r_port_oe[0])
        else $error("port A strobed while input");

    a_lfsr_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_noise_shift != '0)
        else $error("noise shift register stuck at zero");

endmodule

// ===== dv/psg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_checker
// Watches the item streams and configuration port of the sound generator.
// It keeps its own copy of the generator state: prescalers, tone and noise
// counters, the noise shift register, the envelope unit and the port latches.
// Each accepted input item is stepped through that copy to get the expected
// result item. Each accepted result item is compared field by field with the
// oldest expected one. The failure count and the number of results still
// outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------
module psg_checker
    import psg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [2:0]            i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [7:0]  rd;
        logic [15:0] sample;
        logic [7:0]  pa_val;
        logic        pa_stb;
        logic [7:0]  pb_val;
        logic        pb_stb;
    } t_psg_out;

    int log_vol [16] = '{0, 64, 90, 128, 181, 256, 362, 512,
                         724, 1024, 1448, 2048, 2896, 4096, 5793, 8191};

    t_psg_out    psg_out_due [$];
    int          err_count = 0;
    int          due_count = 0;

    logic        mix_on;
    logic [2:0]  chan_keep;
    logic [3:0]  presc;
    logic [3:0]  env_presc;
    logic [11:0] tone_per [3];
    logic [11:0] tone_cnt [3];
    logic        tone_lvl [3];
    logic        tone_off [3];
    logic        noise_off [3];
    logic [3:0]  fix_vol [3];
    logic        use_env [3];
    logic [4:0]  noise_per;
    logic [4:0]  noise_cnt;
    logic        noise_lvl;
    logic        noise_half;
    logic [16:0] lfsr;
    logic [15:0] env_per;
    logic [15:0] env_cnt;
    logic [3:0]  env_pos;
    logic [3:0]  env_lvl;
    logic        env_up;
    logic        env_halt;
    logic [3:0]  env_shape;
    logic        port_out [2];
    logic [7:0]  latch [2];

    assign o_errors  = err_count;
    assign o_pending = due_count;

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report($sformatf("%s: got %h, expected %h", name, got, want));
        end
    endtask

    task automatic power_up();
        int i;
        mix_on = 1'b1;
        chan_keep = 3'd7;
        presc = '0;
        env_presc = '0;
        for (i = 0; i < 3; i++) begin
            tone_per[i] = '0;
            tone_cnt[i] = '0;
            tone_lvl[i] = 1'b1;
            tone_off[i] = 1'b1;
            noise_off[i] = 1'b1;
            fix_vol[i] = '0;
            use_env[i] = 1'b0;
        end
        noise_per = '0;
        noise_cnt = '0;
        noise_lvl = 1'b1;
        noise_half = 1'b0;
        lfsr = 17'd1;
        env_per = '0;
        env_cnt = 16'd1;
        env_pos = 4'd15;
        env_lvl = 4'd15;
        env_up = 1'b0;
        env_halt = 1'b0;
        env_shape = '0;
        for (i = 0; i < 2; i++) begin
            port_out[i] = 1'b0;
            latch[i] = '0;
        end
    endtask

    task automatic env_restart();
        env_halt = 1'b0;
        env_up = env_shape[2];
        env_pos = env_up ? 4'd0 : 4'd15;
        env_lvl = env_pos;
        env_cnt = (env_per != 0) ? env_per : 16'd1;
    endtask

    // shape bits: 0 hold, 1 alternate, 2 attack, 3 continue
    task automatic env_advance();
        if (env_halt) return;
        if (env_cnt != 0) env_cnt--;
        if (env_cnt != 0) return;
        env_cnt = (env_per != 0) ? env_per : 16'd1;
        if (env_up && env_pos != 4'd15) begin
            env_pos++;
        end else if (!env_up && env_pos != 4'd0) begin
            env_pos--;
        end else if (!env_shape[3]) begin
            env_pos = 4'd0;
            env_halt = 1'b1;
        end else if (env_shape[0]) begin
            if (env_shape[1]) env_pos = env_pos ^ 4'd15;
            env_halt = 1'b1;
        end else if (env_shape[1]) begin
            env_up = !env_up;
        end else begin
            env_pos = env_up ? 4'd0 : 4'd15;
        end
        env_lvl = env_pos;
    endtask

    task automatic slow_tick();
        int i;
        logic [3:0] was;
        was = env_presc;
        env_presc = env_presc + 4'd1;
        if (was == 4'd0) env_advance();
        for (i = 0; i < 3; i++) begin
            if (tone_cnt[i] != 0) tone_cnt[i]--;
            if (tone_cnt[i] == 0) begin
                tone_cnt[i] = (tone_per[i] != 0) ? tone_per[i] : 12'd1;
                tone_lvl[i] = !tone_lvl[i];
            end
        end
        if (noise_cnt != 0) noise_cnt--;
        if (noise_cnt == 0) begin
            noise_cnt = (noise_per != 0) ? noise_per : 5'd1;
            noise_half = !noise_half;
            if (noise_half) begin
                noise_lvl = !lfsr[0];
                lfsr = {lfsr[0] ^ lfsr[3], lfsr[16:1]};
            end
        end
    endtask

    function automatic logic [7:0] reg_peek(input logic [3:0] a, input logic [7:0] pa,
                                            input logic [7:0] pb);
        logic [7:0] v;
        v = '0;
        case (a)
            REG_TONE_A_FINE, REG_TONE_B_FINE, REG_TONE_C_FINE: v = tone_per[a[2:1]][7:0];
            REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE: begin
                v = {4'd0, tone_per[a[2:1]][11:8]};
            end
            REG_NOISE_PERIOD: v = {3'd0, noise_per};
            REG_MIXER_CTL: begin
                v = {port_out[1], port_out[0], noise_off[2], noise_off[1], noise_off[0],
                     tone_off[2], tone_off[1], tone_off[0]};
            end
            REG_VOL_A: v = {3'd0, use_env[0], fix_vol[0]};
            REG_VOL_B: v = {3'd0, use_env[1], fix_vol[1]};
            REG_VOL_C: v = {3'd0, use_env[2], fix_vol[2]};
            REG_ENV_FINE: v = env_per[7:0];
            REG_ENV_COARSE: v = env_per[15:8];
            REG_ENV_SHAPE: v = {4'd0, env_shape};
            REG_PORT_A: v = port_out[0] ? latch[0] : pa;
            default: v = port_out[1] ? latch[1] : pb;
        endcase
        return v;
    endfunction

    task automatic reg_poke(input logic [3:0] a, input logic [7:0] v,
                            output logic stb_a, output logic stb_b);
        int i;
        logic was_a;
        logic was_b;
        stb_a = 1'b0;
        stb_b = 1'b0;
        case (a)
            REG_TONE_A_FINE, REG_TONE_B_FINE, REG_TONE_C_FINE: tone_per[a[2:1]][7:0] = v;
            REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE: begin
                tone_per[a[2:1]][11:8] = v[3:0];
            end
            REG_NOISE_PERIOD: noise_per = v[4:0];
            REG_MIXER_CTL: begin
                was_a = port_out[0];
                was_b = port_out[1];
                for (i = 0; i < 3; i++) begin
                    tone_off[i] = v[i];
                    noise_off[i] = v[i + 3];
                end
                port_out[0] = v[6];
                port_out[1] = v[7];
                stb_a = !was_a && v[6];
                stb_b = !was_b && v[7];
            end
            REG_VOL_A, REG_VOL_B, REG_VOL_C: begin
                i = int'(a - REG_VOL_A);
                fix_vol[i] = v[3:0];
                use_env[i] = v[4];
            end
            REG_ENV_FINE: env_per[7:0] = v;
            REG_ENV_COARSE: env_per[15:8] = v;
            REG_ENV_SHAPE: begin
                env_shape = v[3:0];
                env_restart();
            end
            REG_PORT_A: begin
                latch[0] = v;
                stb_a = port_out[0];
            end
            default: begin
                latch[1] = v;
                stb_b = port_out[1];
            end
        endcase
    endtask

    function automatic logic [15:0] mixed_level();
        int sum;
        int i;
        logic [3:0] l;
        sum = 0;
        if (!mix_on) return 16'd0;
        for (i = 0; i < 3; i++) begin
            if (chan_keep[i]) begin
                l = use_env[i] ? env_lvl : fix_vol[i];
                if ((tone_lvl[i] || tone_off[i]) && (noise_lvl || noise_off[i]))
                    sum += log_vol[l];
                else
                    sum -= log_vol[l];
            end
        end
        return sum[15:0];
    endfunction

    task automatic psg_step(input logic [1:0] act, input logic [IN_DATA_W-1:0] d,
                            output t_psg_out r);
        logic [3:0] was;
        logic stb_a;
        logic stb_b;
        r = '0;
        stb_a = 1'b0;
        stb_b = 1'b0;
        case (act)
            ACT_TICK: begin
                was = presc;
                presc = presc + 4'd1;
                if (was == 4'd0) slow_tick();
            end
            ACT_WRITE: reg_poke(d[3:0], d[11:4], stb_a, stb_b);
            ACT_READ: r.rd = reg_peek(d[3:0], d[19:12], d[27:20]);
            default: ;
        endcase
        r.sample = mixed_level();
        r.pa_val = latch[0];
        r.pa_stb = stb_a;
        r.pb_val = latch[1];
        r.pb_stb = stb_b;
    endtask

    always @(posedge i_clk) begin
        t_psg_out want;
        t_psg_out fresh;
        if (!i_rst_n) begin
            power_up();
            psg_out_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MASTER_ENABLE: mix_on = i_cfg_data[0];
                    default: chan_keep = i_cfg_data;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (psg_out_due.size() == 0) begin
                    report($sformatf("result item with none expected: %h", m_tdata));
                end else begin
                    want = psg_out_due.pop_front();
                    check_field("read_value", 16'(m_tdata[7:0]), 16'(want.rd));
                    check_field("mixed_sample", m_tdata[23:8], want.sample);
                    check_field("port_a_value", 16'(m_tdata[31:24]), 16'(want.pa_val));
                    check_field("port_a_strobe", 16'(m_tdata[32]), 16'(want.pa_stb));
                    check_field("port_b_value", 16'(m_tdata[40:33]), 16'(want.pb_val));
                    check_field("port_b_strobe", 16'(m_tdata[41]), 16'(want.pb_stb));
                    check_field("padding", 16'(m_tdata[OUT_DATA_W-1:42]), 16'd0);
                end
            end
            if (s_tvalid && s_tready) begin
                psg_step(s_tuser, s_tdata, fresh);
                psg_out_due.push_back(fresh);
            end
        end
        due_count = psg_out_due.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the tone, noise and envelope sound generator.
// A short directed run covers register extremes, read-back masking, port
// strobes, shape restarts and the unused action code. Random phases follow
// under several mix settings, then tick runs under envelope control with
// fresh shapes. Both stream sides idle at random, and the receiver holds
// off for long stretches so the block fills and stalls its input.
// ----------------------------------------------------------------------------
module tb;
    import psg_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int LONG_HOLD = 300;
    localparam int CYCLE_LIMIT = 1500000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // [3:0] reg_addr, [11:4] data, [19:12] port_a_pins, [27:20] port_b_pins
    logic [IN_DATA_W-1:0]  s_tdata;
    // [1:0] action
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // [7:0] read_value, [23:8] mixed_sample, [31:24] port_a_value,
    // [32] port_a_strobe, [40:33] port_b_value, [41] port_b_strobe
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  i_cfg_we;
    logic [0:0]            i_cfg_index;
    logic [2:0]            i_cfg_data;

    int errors;
    int pending;
    int sent_count = 0;
    int rx_count = 0;
    int cycles = 0;
    bit tx_fast = 1'b0;
    bit rx_fast = 1'b0;

    psg_tone_noise_envelope dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    psg_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_item(input logic [1:0] act, input logic [3:0] a,
                             input logic [7:0] d);
        int gap;
        logic [7:0] pa;
        logic [7:0] pb;
        gap = tx_fast ? 0 : $urandom_range(0, 10);
        pa = 8'($urandom);
        pb = 8'($urandom);
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser = act;
        s_tdata = {4'd0, pb, pa, d, a};
        do @(posedge i_clk); while (!s_tready);
        sent_count++;
        if (sent_count % 150 == 0) tx_fast = ($urandom_range(0, 3) == 0);
    endtask

    // keep periods mostly short so tones, noise and envelope all move
    function automatic logic [7:0] pick_data(input logic [3:0] a);
        logic [7:0] v;
        v = 8'($urandom);
        case (a)
            REG_TONE_A_FINE, REG_TONE_B_FINE, REG_TONE_C_FINE: begin
                if ($urandom_range(0, 3) != 0) v = 8'($urandom_range(0, 6));
            end
            REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE: begin
                if ($urandom_range(0, 3) != 0) v[3:0] = 4'd0;
            end
            REG_ENV_FINE: if ($urandom_range(0, 3) != 0) v = 8'($urandom_range(0, 2));
            REG_ENV_COARSE: if ($urandom_range(0, 7) != 0) v = 8'd0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_item(input int tick_pct, input int write_pct);
        int r;
        logic [3:0] a;
        r = $urandom_range(0, 99);
        a = 4'($urandom);
        if (r < tick_pct) begin
            send_item(ACT_TICK, a, 8'($urandom));
        end else if (r < tick_pct + write_pct) begin
            if (a == REG_ENV_SHAPE && $urandom_range(0, 3) != 0) a = REG_VOL_A;
            send_item(ACT_WRITE, a, pick_data(a));
        end else if (r < 99) begin
            send_item(ACT_READ, a, 8'($urandom));
        end else begin
            send_item(ACT_NONE, a, 8'($urandom));
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic [2:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_directed();
        send_item(ACT_WRITE, REG_TONE_A_FINE, 8'hFF);
        send_item(ACT_WRITE, REG_TONE_A_COARSE, 8'hFF);
        send_item(ACT_READ, REG_TONE_A_COARSE, 8'h00);
        send_item(ACT_WRITE, REG_NOISE_PERIOD, 8'hFF);
        send_item(ACT_READ, REG_NOISE_PERIOD, 8'h00);
        send_item(ACT_WRITE, REG_VOL_A, 8'hFF);
        send_item(ACT_READ, REG_VOL_A, 8'h00);
        send_item(ACT_WRITE, REG_PORT_A, 8'hA5);
        send_item(ACT_READ, REG_PORT_A, 8'h00);
        send_item(ACT_WRITE, REG_MIXER_CTL, 8'hC0);
        send_item(ACT_READ, REG_PORT_A, 8'h00);
        send_item(ACT_WRITE, REG_PORT_B, 8'h5A);
        send_item(ACT_WRITE, REG_MIXER_CTL, 8'hFF);
        send_item(ACT_READ, REG_MIXER_CTL, 8'h00);
        send_item(ACT_WRITE, REG_ENV_FINE, 8'hFF);
        send_item(ACT_WRITE, REG_ENV_COARSE, 8'hFF);
        send_item(ACT_READ, REG_ENV_COARSE, 8'h00);
        send_item(ACT_WRITE, REG_ENV_SHAPE, 8'hFF);
        send_item(ACT_READ, REG_ENV_SHAPE, 8'h00);
        send_item(ACT_NONE, REG_PORT_B, 8'hFF);
        send_item(ACT_WRITE, REG_ENV_COARSE, 8'h00);
        send_item(ACT_WRITE, REG_TONE_A_COARSE, 8'h00);
        send_item(ACT_WRITE, REG_TONE_A_FINE, 8'h00);
        send_item(ACT_WRITE, REG_MIXER_CTL, 8'h00);
        send_item(ACT_TICK, 4'd0, 8'h00);
    endtask

    task automatic env_sweep(input logic [3:0] shp);
        logic [3:0] lvl;
        send_item(ACT_WRITE, REG_ENV_FINE, 8'h00);
        send_item(ACT_WRITE, REG_ENV_COARSE, 8'h00);
        lvl = 4'($urandom);
        send_item(ACT_WRITE, REG_VOL_A, {4'h1, lvl});
        lvl = 4'($urandom);
        send_item(ACT_WRITE, REG_VOL_B, {4'h1, lvl});
        lvl = 4'($urandom);
        send_item(ACT_WRITE, REG_VOL_C, {3'd0, lvl[0], lvl});
        send_item(ACT_WRITE, REG_ENV_SHAPE, {4'($urandom_range(0, 15)), shp});
        repeat (230) random_item(97, 0);
    endtask

    // receiver: own stall per item, with long hold-offs to back up the block
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            stall = rx_fast ? 0 : $urandom_range(0, 10);
            if (rx_count == 300 || rx_count == 1200) stall = LONG_HOLD;
            @(negedge i_clk);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready = 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            rx_count++;
            if (rx_count % 250 == 0) rx_fast = ($urandom_range(0, 2) == 0);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int ph;
        int r;
        logic [3:0] shp;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = ACT_TICK;
        s_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_MASTER_ENABLE;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        write_cfg(CFG_MASTER_ENABLE, 3'd1);
        write_cfg(CFG_CHANNEL_MASK, 3'd7);
        run_directed();
        for (ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: write_cfg(CFG_CHANNEL_MASK, 3'd7);
                1: begin
                    write_cfg(CFG_MASTER_ENABLE, 3'd0);
                    write_cfg(CFG_CHANNEL_MASK, 3'd5);
                end
                2: begin
                    write_cfg(CFG_MASTER_ENABLE, 3'd1);
                    write_cfg(CFG_CHANNEL_MASK, 3'd0);
                end
                default: write_cfg(CFG_CHANNEL_MASK, 3'($urandom_range(1, 6)));
            endcase
            tx_fast = (ph == 2);
            repeat (200) random_item(75, 17);
        end
        for (ph = 0; ph < 3; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_cfg(CFG_CHANNEL_MASK, 3'd7);
                    shp = $urandom_range(0, 1) ? 4'd10 : 4'd14;
                end
                1: shp = 4'd9 + 4'($urandom_range(0, 3) * 2);
                default: begin
                    write_cfg(CFG_CHANNEL_MASK, 3'($urandom_range(0, 7)));
                    r = $urandom_range(0, 9);
                    shp = (r < 8) ? 4'(r) : ((r == 8) ? 4'd8 : 4'd12);
                end
            endcase
            env_sweep(shp);
        end
        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/psg_pkg.sv
hw/rtl/psg_env.sv
hw/rtl/psg_tone_noise_envelope.sv
dv/psg_checker.sv
dv/tb.sv
